>>> rtl/tpc_pkg.sv
// ============================================================================
// tpc_pkg
// Shared widths, register codes and divider stage type for the touch
// pressure calculator.
// ============================================================================
`default_nettype none

package tpc_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 12;
    localparam int PLATE_W    = 12;
    localparam int THRESH_W   = 24;
    localparam int PRESSURE_W = 29;

    // Product widths: plate * x, then times |z2 - z1|, and threshold * z1.
    localparam int PX_W     = PLATE_W + SAMPLE_W;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int MAG_W    = PX_W + SAMPLE_W;
    localparam int LIMIT_W  = THRESH_W + SAMPLE_W;
    localparam int CMP_W    = LIMIT_W + 12;

    // The 256 of the divisor is taken off the dividend as a shift.
    localparam int DIV_SHIFT = 8;
    localparam int QUOT_W    = MAG_W - DIV_SHIFT;
    localparam int DIV_STEPS = QUOT_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = THRESH_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_PLATE_RESISTANCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOUCH_THRESHOLD  = 1'b1;

    localparam logic [PLATE_W-1:0]  PLATE_RESET  = 12'd400;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd1000;

    // One stage of the divider pipe, with the side data that rides along.
    // The word starts as the dividend and fills with quotient bits.
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] rem;
        logic [QUOT_W-1:0]   word;
        logic [SAMPLE_W-1:0] divisor;
        logic                neg;
        logic                touched;
        logic                zero_div;
        logic [SAMPLE_W-1:0] x_pos;
        logic [SAMPLE_W-1:0] y_pos;
    } div_stage_t;

    // One restoring division step: bring down a dividend bit, subtract the
    // divisor if it fits, and shift the quotient bit in.
    function automatic div_stage_t div_step(div_stage_t s);
        div_stage_t          r;
        logic [SAMPLE_W:0]   trial;
        logic [SAMPLE_W:0]   diff;
        logic                fits;
        r     = s;
        trial = {s.rem, s.word[QUOT_W-1]};
        diff  = trial - {1'b0, s.divisor};
        fits  = (trial >= {1'b0, s.divisor});
        r.rem  = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
        r.word = {s.word[QUOT_W-2:0], fits};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tpc_div_pipe.sv
// ============================================================================
// tpc_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module tpc_div_pipe (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      advance,
    input  wire tpc_pkg::div_stage_t stage_in,
    output tpc_pkg::div_stage_t      stage_out
);
    import tpc_pkg::*;

    div_stage_t stage_reg [DIV_STEPS];
    div_stage_t step_src  [DIV_STEPS];

    // Each stage takes the one before it; the first takes the pipe input.
    assign step_src[0] = stage_in;

    genvar i;
    generate
        for (i = 1; i < DIV_STEPS; i++) begin : g_src
            assign step_src[i] = stage_reg[i-1];
        end

        for (i = 0; i < DIV_STEPS; i++) begin : g_stage
            // The whole pipe moves together, or holds while the output stalls.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg[i] <= '0;
                end
                else if (advance)
                begin
                    stage_reg[i] <= div_step(step_src[i]);
                end
            end
        end
    endgenerate

    assign stage_out = stage_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/touch_pressure_calc_unit.sv
// ============================================================================
// touch_pressure_calc_unit
// Resistive touch pressure from Z1/Z2 samples, passed through a deep
// pipeline of two multiply stages and a bit-per-stage divider.
// ============================================================================
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_stall | x, y, z1, z2 samples
//  out     | output    | out_valid/out_stall | x, y, pressure, touched, zero_div
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
//  One item per cycle while the output does not stall; the pipeline is two
//  multiply stages, 28 divider stages (one quotient bit each, set by the
//  restoring divider) and the output register.
//  Reset clears every pipeline valid bit and loads plate resistance 400 and
//  threshold 1000.
//  While the output register holds a stalled transfer the whole pipeline
//  freezes and in_stall is raised; nothing is lost or repeated.
//
`default_nettype none

module touch_pressure_calc_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    // Configuration.
    input  wire                               cfg_write,
    input  wire [tpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [tpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input channel.
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire [tpc_pkg::SAMPLE_W-1:0]       x_sample,
    input  wire [tpc_pkg::SAMPLE_W-1:0]       y_sample,
    input  wire [tpc_pkg::SAMPLE_W-1:0]       z1_sample,
    input  wire [tpc_pkg::SAMPLE_W-1:0]       z2_sample,
    // Output channel.
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [tpc_pkg::SAMPLE_W-1:0]      x_position,
    output logic [tpc_pkg::SAMPLE_W-1:0]      y_position,
    output logic signed [tpc_pkg::PRESSURE_W-1:0] pressure,
    output logic                              touched,
    output logic                              zero_divisor
);
    import tpc_pkg::*;

    logic [PLATE_W-1:0]  plate_res_reg;
    logic [THRESH_W-1:0] thresh_reg;

    logic                advance;

    // Stage 1 registers.
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_x_reg;
    logic [SAMPLE_W-1:0] s1_y_reg;
    logic [SAMPLE_W-1:0] s1_z1_reg;
    logic [PX_W-1:0]     s1_px_reg;
    logic [DIFF_W-1:0]   s1_diff_reg;
    logic [LIMIT_W-1:0]  s1_limit_reg;

    // Stage 2 registers.
    logic                s2_valid_reg;
    logic [SAMPLE_W-1:0] s2_x_reg;
    logic [SAMPLE_W-1:0] s2_y_reg;
    logic [SAMPLE_W-1:0] s2_z1_reg;
    logic [MAG_W-1:0]    s2_mag_reg;
    logic                s2_neg_reg;
    logic [LIMIT_W-1:0]  s2_limit_reg;

    logic [DIFF_W-1:0]   diff_neg;
    logic [SAMPLE_W-1:0] diff_abs;
    logic                s2_zero;
    logic                s2_touched;

    div_stage_t          div_in;
    div_stage_t          div_out;

    // Output register.
    logic                      out_valid_reg;
    logic [SAMPLE_W-1:0]       out_x_reg;
    logic [SAMPLE_W-1:0]       out_y_reg;
    logic [PRESSURE_W-1:0]     out_pressure_reg;
    logic [PRESSURE_W-1:0]     pressure_next;
    logic [PRESSURE_W-1:0]     quot_ext;
    logic                      out_touched_reg;
    logic                      out_zero_reg;

    // Register writes; the index covers exactly the two registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plate_res_reg <= PLATE_RESET;
            thresh_reg    <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PLATE_RESISTANCE: plate_res_reg <= cfg_data[PLATE_W-1:0];
                CFG_TOUCH_THRESHOLD:  thresh_reg    <= cfg_data;
            endcase
        end
    end

    // The pipeline moves unless a finished result is waiting to be taken.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Stage 1: plate * x, z2 - z1 and threshold * z1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg     <= x_sample;
            s1_y_reg     <= y_sample;
            s1_z1_reg    <= z1_sample;
            s1_px_reg    <= PX_W'(plate_res_reg) * PX_W'(x_sample);
            s1_diff_reg  <= {1'b0, z2_sample} - {1'b0, z1_sample};
            s1_limit_reg <= LIMIT_W'(thresh_reg) * LIMIT_W'(z1_sample);
        end
    end

    // Stage 2: magnitude of the numerator and its sign.
    assign diff_neg = -s1_diff_reg;
    assign diff_abs = s1_diff_reg[DIFF_W-1] ? diff_neg[SAMPLE_W-1:0]
                                            : s1_diff_reg[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_z1_reg    <= s1_z1_reg;
            s2_mag_reg   <= MAG_W'(s1_px_reg) * MAG_W'(diff_abs);
            s2_neg_reg   <= s1_diff_reg[DIFF_W-1];
            s2_limit_reg <= s1_limit_reg;
        end
    end

    // Touch test, for nonzero z1: a nonzero value that is negative, or whose magnitude is
    // below threshold * 4096 * z1.
    assign s2_zero    = (s2_z1_reg == '0);
    assign s2_touched = !s2_zero && (s2_mag_reg != '0) &&
                        (s2_neg_reg ||
                         ({{(CMP_W-MAG_W){1'b0}}, s2_mag_reg} < {s2_limit_reg, 12'd0}));

    // Divider feed: dividend is the magnitude over 256, divisor is z1.
    always_comb
    begin
        div_in          = '0;
        div_in.valid    = s2_valid_reg;
        div_in.rem      = '0;
        div_in.word     = s2_mag_reg[MAG_W-1:DIV_SHIFT];
        div_in.divisor  = s2_z1_reg;
        div_in.neg      = s2_neg_reg;
        div_in.touched  = s2_touched;
        div_in.zero_div = s2_zero;
        div_in.x_pos    = s2_x_reg;
        div_in.y_pos    = s2_y_reg;
    end

    tpc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .stage_in  (div_in),
        .stage_out (div_out)
    );

    // Output stage: apply the sign, and clear the result when z1 was zero.
    assign quot_ext      = {{(PRESSURE_W-QUOT_W){1'b0}}, div_out.word};
    assign pressure_next = div_out.zero_div ? '0 :
                           (div_out.neg ? -quot_ext : quot_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_x_reg        <= div_out.x_pos;
            out_y_reg        <= div_out.y_pos;
            out_pressure_reg <= pressure_next;
            out_touched_reg  <= div_out.touched;
            out_zero_reg     <= div_out.zero_div;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_position   = out_x_reg;
    assign y_position   = out_y_reg;
    assign pressure     = $signed(out_pressure_reg);
    assign touched      = out_touched_reg;
    assign zero_divisor = out_zero_reg;

`ifndef NO_ASSERTIONS
    // A zero divisor always gives a cleared result.
    a_zero_div_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_divisor) |-> (pressure == '0 && !touched))
        else $error("zero divisor result not cleared");

    // A negative pressure is always below threshold, so it counts as a touch.
    a_negative_touched: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pressure[PRESSURE_W-1]) |-> touched)
        else $error("negative pressure without touch flag");

    // The input is held off exactly while a result waits at the output.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without an output stall");
`endif

endmodule

`default_nettype wire
